// File: rtl/core/pcv_pkg.sv
// Shared types, register indexes, reset values and the CRC byte update for
// the packet checksum verifier. No dependencies.
`default_nettype none

package pcv_pkg;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CHECKSUM_MODE = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MIN_LENGTH    = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CAPACITY      = 2'd2;

   localparam logic        MODE_RESET     = 1'b0;
   localparam logic [15:0] MIN_LEN_RESET  = 16'd2;
   localparam logic [15:0] CAPACITY_RESET = 16'd2048;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam logic [15:0] PARAM_HI_POS = 16'd6;
   localparam logic [15:0] PARAM_LO_POS = 16'd7;
   localparam logic [15:0] PARAM_MIN_LEN = 16'd8;
   localparam logic [15:0] CHECK_BYTES  = 16'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic        packet_ok;
      logic [15:0] computed_check;
      logic [15:0] received_check;
      logic [15:0] stored_length;
      logic [15:0] param_length;
   } rsp_type;

   typedef struct packed {
      logic        checksum_mode;
      logic [15:0] min_length;
      logic [15:0] capacity;
   } cfg_type;

   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/packet_checksum_verifier.sv
// An accepted word is held in the input register; its result is registered on rsp.
// Throughput: one word per cycle unless rsp_stall holds a result; the input register
// and result register are separated by one CRC-16 or sum byte update and compare.
// At most one result per packet, given with the word that carries last_byte.
// Synchronous active-high reset clears the check state and restores the
// register defaults: CRC mode, minimum length 2, capacity 2048.
`default_nettype none

module packet_checksum_verifier (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire pcv_pkg::req_type                     req_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output pcv_pkg::rsp_type                          rsp_data,
   input  wire logic                                 csr_write,
   input  wire logic [pcv_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [pcv_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);

   pcv_pkg::cfg_type cfg_ff, cfg_in;
   logic             rsp_valid_ff, rsp_valid_in;
   pcv_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic             advance;
   logic             item_valid;
   pcv_pkg::req_type item_data;
   logic             res_valid;
   pcv_pkg::rsp_type res_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            pcv_pkg::CSR_CHECKSUM_MODE: cfg_in.checksum_mode = csr_wdata[0];
            pcv_pkg::CSR_MIN_LENGTH:    cfg_in.min_length    = csr_wdata;
            pcv_pkg::CSR_CAPACITY:      cfg_in.capacity      = csr_wdata;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.checksum_mode <= pcv_pkg::MODE_RESET;
         cfg_ff.min_length    <= pcv_pkg::MIN_LEN_RESET;
         cfg_ff.capacity      <= pcv_pkg::CAPACITY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign advance = !rsp_valid_ff || !rsp_stall;

   pcv_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .advance    (advance),
      .item_valid (item_valid),
      .item_data  (item_data)
   );

   pcv_check u_check (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (item_valid),
      .item_data  (item_data),
      .advance    (advance),
      .res_valid  (res_valid),
      .res_data   (res_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_data_in = res_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// File: rtl/core/pcv_in_stage.sv
// Input register of the packet checksum verifier: holds one accepted word
// until the check stage takes it. Depends on pcv_pkg.
`default_nettype none

module pcv_in_stage (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire pcv_pkg::req_type req_data,
   input  wire logic            advance,
   output logic                 item_valid,
   output pcv_pkg::req_type     item_data
);

   logic             valid_ff, valid_in;
   pcv_pkg::req_type data_ff, data_in;
   logic             accept;

   assign req_stall = valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (accept) begin
         valid_in = 1'b1;
         data_in  = req_data;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign item_valid = valid_ff;
   assign item_data  = data_ff;

endmodule

`default_nettype wire

// File: rtl/core/pcv_check.sv
// Running check state and result formation for one packet byte per cycle while advance is high.
// Depends on pcv_pkg.
`default_nettype none

module pcv_check (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire pcv_pkg::cfg_type cfg,
   input  wire logic             item_valid,
   input  wire pcv_pkg::req_type item_data,
   input  wire logic             advance,
   output logic                  res_valid,
   output pcv_pkg::rsp_type      res_data
);

   logic [15:0] crc_ff, crc_in;
   logic [15:0] sum_ff, sum_in;
   logic [15:0] count_ff, count_in;
   logic [7:0]  d0_ff, d0_in;
   logic [7:0]  d1_ff, d1_in;
   logic [15:0] field_ff, field_in;

   logic        proc;
   logic [15:0] crc_n, sum_n, count_n, field_n, received, computed;
   logic [7:0]  d0_n, d1_n;
   logic        ok;

   assign proc = item_valid && advance;

   always_comb begin
      crc_n   = crc_ff;
      sum_n   = sum_ff;
      count_n = count_ff;
      d0_n    = d0_ff;
      d1_n    = d1_ff;
      field_n = field_ff;
      if (count_ff < cfg.capacity) begin
         if (count_ff >= pcv_pkg::CHECK_BYTES) begin
            crc_n = pcv_pkg::crc_update(crc_ff, d0_ff);
            sum_n = sum_ff + {8'h00, d0_ff};
         end
         d0_n = d1_ff;
         d1_n = item_data.data_byte;
         if (count_ff == pcv_pkg::PARAM_HI_POS) begin
            field_n = {item_data.data_byte, field_ff[7:0]};
         end else if (count_ff == pcv_pkg::PARAM_LO_POS) begin
            field_n = {field_ff[15:8], item_data.data_byte};
         end
         count_n = count_ff + 16'd1;
      end

      computed = cfg.checksum_mode ? sum_n : crc_n;
      received = {d0_n, d1_n};
      ok = (count_n >= pcv_pkg::CHECK_BYTES) && (count_n >= cfg.min_length) &&
           (received == computed);

      res_valid               = proc && item_data.last_byte;
      res_data.packet_ok      = ok;
      res_data.computed_check = computed;
      res_data.received_check = received;
      res_data.stored_length  = count_n;
      res_data.param_length   = (ok && count_n >= pcv_pkg::PARAM_MIN_LEN) ? field_n : 16'd0;

      crc_in   = crc_ff;
      sum_in   = sum_ff;
      count_in = count_ff;
      d0_in    = d0_ff;
      d1_in    = d1_ff;
      field_in = field_ff;
      if (proc) begin
         if (item_data.last_byte) begin
            crc_in   = pcv_pkg::CRC_INIT;
            sum_in   = 16'd0;
            count_in = 16'd0;
            d0_in    = 8'd0;
            d1_in    = 8'd0;
            field_in = 16'd0;
         end else begin
            crc_in   = crc_n;
            sum_in   = sum_n;
            count_in = count_n;
            d0_in    = d0_n;
            d1_in    = d1_n;
            field_in = field_n;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff   <= pcv_pkg::CRC_INIT;
         sum_ff   <= 16'd0;
         count_ff <= 16'd0;
         d0_ff    <= 8'd0;
         d1_ff    <= 8'd0;
         field_ff <= 16'd0;
      end else begin
         crc_ff   <= crc_in;
         sum_ff   <= sum_in;
         count_ff <= count_in;
         d0_ff    <= d0_in;
         d1_ff    <= d1_in;
         field_ff <= field_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (proc && item_data.last_byte) |=> (count_ff == 16'd0 && crc_ff == pcv_pkg::CRC_INIT &&
                                         sum_ff == 16'd0 && field_ff == 16'd0))
      else $error("check state not cleared after the last word of a packet");
   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      !proc |=> ($stable(count_ff) && $stable(crc_ff) && $stable(sum_ff)))
      else $error("check state changed without a word being processed");
   a_ok_needs_match: assert property (@(posedge clock)
      (res_valid && res_data.packet_ok) |->
         (res_data.received_check == res_data.computed_check &&
          res_data.stored_length >= pcv_pkg::CHECK_BYTES))
      else $error("pass reported without a matching check or enough bytes");
   a_param_needs_ok: assert property (@(posedge clock)
      (res_valid && res_data.param_length != 16'd0) |->
         (res_data.packet_ok && res_data.stored_length >= pcv_pkg::PARAM_MIN_LEN))
      else $error("parameter length reported for a failed or short packet");
`endif

endmodule

`default_nettype wire
